// ===== hdl/ast_pkg.sv =====
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types, character codes and token kinds for the source tokenizer.
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int OUT_OFS_W       = 16;
    localparam int KIND_W          = 5;
    localparam int ERR_W           = 3;
    localparam int TDATA_W         = 40;
    localparam int PAD_W           = TDATA_W - 2 * OUT_OFS_W - ERR_W;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_COMMENT = 3'd4,
        MODE_TAIL    = 3'd5,
        MODE_ERROR   = 3'd6
    } t_mode;

    localparam logic [KIND_W-1:0] K_IDENT  = 5'd0;
    localparam logic [KIND_W-1:0] K_LABEL  = 5'd1;
    localparam logic [KIND_W-1:0] K_STRING = 5'd2;
    localparam logic [KIND_W-1:0] K_NUMBER = 5'd3;
    localparam logic [KIND_W-1:0] K_NONE   = 5'd0;
    localparam logic [KIND_W-1:0] K_BREAK  = 5'd22;
    localparam logic [KIND_W-1:0] K_END    = 5'd23;
    localparam logic [KIND_W-1:0] K_ERROR  = 5'd24;

    localparam logic [ERR_W-1:0] E_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] E_UNKNOWN   = 3'd1;
    localparam logic [ERR_W-1:0] E_DIRECTIVE = 3'd2;
    localparam logic [ERR_W-1:0] E_BAD_NUM   = 3'd3;
    localparam logic [ERR_W-1:0] E_UNCLOSED  = 3'd4;
    localparam logic [ERR_W-1:0] E_ESC_QUOTE = 3'd5;

    localparam logic [7:0] C_NUL       = 8'h00;
    localparam logic [7:0] C_TAB       = 8'h09;
    localparam logic [7:0] C_LF        = 8'h0A;
    localparam logic [7:0] C_VT        = 8'h0B;
    localparam logic [7:0] C_FF        = 8'h0C;
    localparam logic [7:0] C_CR        = 8'h0D;
    localparam logic [7:0] C_SPACE     = 8'h20;
    localparam logic [7:0] C_QUOTE     = 8'h22;
    localparam logic [7:0] C_PERCENT   = 8'h25;
    localparam logic [7:0] C_COLON     = 8'h3A;
    localparam logic [7:0] C_SEMI      = 8'h3B;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_UNDER     = 8'h5F;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [OUT_OFS_W-1:0] start;
        logic [OUT_OFS_W-1:0] length;
        logic [ERR_W-1:0]     err;
        logic                 last;
    } t_result;

    // one-character token kind, K_NONE when the byte is not one
    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        begin
            unique case (c)
                8'h23:   k = 5'd4;   // #
                8'h21:   k = 5'd5;   // !
                8'h2B:   k = 5'd6;   // +
                8'h2D:   k = 5'd7;   // -
                8'h2A:   k = 5'd8;   // *
                8'h2F:   k = 5'd9;   // /
                8'h2C:   k = 5'd10;  // ,
                8'h3B:   k = 5'd11;  // ;
                8'h3A:   k = 5'd12;  // :
                8'h3D:   k = 5'd13;  // =
                8'h3E:   k = 5'd14;  // >
                8'h3C:   k = 5'd15;  // <
                8'h28:   k = 5'd16;  // (
                8'h29:   k = 5'd17;  // )
                8'h5B:   k = 5'd18;  // [
                8'h5D:   k = 5'd19;  // ]
                8'h7B:   k = 5'd20;  // {
                8'h7D:   k = 5'd21;  // }
                default: k = K_NONE;
            endcase
            return k;
        end
    endfunction

    function automatic t_result mk_result(input logic [KIND_W-1:0] kind,
                                          input logic [OUT_OFS_W-1:0] start,
                                          input logic [OUT_OFS_W-1:0] length,
                                          input logic [ERR_W-1:0] err);
        t_result r;
        begin
            r.kind   = kind;
            r.start  = start;
            r.length = length;
            r.err    = err;
            r.last   = 1'b0;
            return r;
        end
    endfunction

endpackage

// ===== hdl/assembly_source_tokenizer.sv =====
// ----------------------------------------------------------------------------
// assembly_source_tokenizer
// Byte-stream tokenizer for assembly source: identifiers, labels, numbers,
// strings, one-character tokens, line breaks, end and error tokens.
// ----------------------------------------------------------------------------
// A token is written into the result queue when its byte is accepted; m_axis reads the queue head.
// Throughput: one byte per cycle while the queue has room; a byte that causes
// two tokens writes both at once into the four-entry result queue.
// Input is taken while the queue has room for two tokens.
// Reset (synchronous, i_rst_n low) clears the scan state and empties the queue.
module assembly_source_tokenizer #(
    parameter int OFFSET_BITS = ast_pkg::OFFSET_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] text_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [15:0] token_start, [31:16] token_length, [34:32] error_code
    output logic [ast_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [ast_pkg::KIND_W-1:0]  m_axis_tuser,   // [4:0] token_kind
    output logic                        m_axis_tlast    // last_of_item
);
    import ast_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_begin, n_begin;
    logic                   r_esc, n_esc;
    logic                   r_bs, n_bs;
    logic                   r_prev_break, n_prev_break;
    logic                   r_any, n_any;

    t_result                r_fifo [DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]         r_count, n_count;

    logic                   w_accept, w_pop;
    logic [7:0]             c;
    logic                   w_nul, w_lf, w_cr, w_space, w_digit, w_alpha, w_ident_c;
    logic [KIND_W-1:0]      w_single;
    logic [OFFSET_BITS-1:0] w_span, w_pos_p1;
    logic [OUT_OFS_W-1:0]   w_pos16, w_begin16, w_span16;

    t_result                w_res [2];
    logic [1:0]             w_n;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_pop    = m_axis_tvalid && m_axis_tready;
    assign c        = s_axis_tdata;

    assign w_nul     = (c == C_NUL);
    assign w_lf      = (c == C_LF);
    assign w_cr      = (c == C_CR);
    assign w_space   = (c == C_SPACE) || (c == C_TAB) || w_lf || (c == C_VT)
                       || (c == C_FF) || w_cr;
    assign w_digit   = (c >= 8'h30) && (c <= 8'h39);
    assign w_alpha   = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign w_ident_c = w_alpha || w_digit || (c == C_UNDER);
    assign w_single  = single_kind(c);

    assign w_span    = r_pos - r_begin;
    assign w_pos_p1  = r_pos + OFFSET_BITS'(1);
    assign w_pos16   = OUT_OFS_W'(r_pos);
    assign w_begin16 = OUT_OFS_W'(r_begin);
    assign w_span16  = OUT_OFS_W'(w_span);

    // next scan state
    always_comb begin
        logic disp;
        n_mode  = r_mode;
        n_begin = r_begin;
        n_esc   = r_esc;
        n_bs    = r_bs;
        n_pos   = r_pos;
        disp    = 1'b0;
        if (w_accept) begin
            n_pos = w_pos_p1;
            if (w_nul) begin
                n_mode  = MODE_IDLE;
                n_begin = '0;
                n_esc   = 1'b0;
                n_bs    = 1'b0;
                n_pos   = '0;
            end else begin
                unique case (r_mode)
                    MODE_IDENT: begin
                        if (!w_ident_c) begin
                            if (c == C_COLON) n_mode = MODE_IDLE;
                            else disp = 1'b1;
                        end
                    end
                    MODE_NUMBER: begin
                        if (!w_digit) begin
                            if (w_space || (w_single != K_NONE)) disp = 1'b1;
                            else n_mode = MODE_ERROR;
                        end
                    end
                    MODE_STRING: begin
                        if (r_bs && (c == C_QUOTE)) begin
                            n_esc = ~r_esc;
                            n_bs  = 1'b0;
                        end else if (c == C_QUOTE) begin
                            n_mode = r_esc ? MODE_ERROR : MODE_IDLE;
                        end else begin
                            n_bs = (c == C_BACKSLASH);
                        end
                    end
                    MODE_COMMENT: begin
                        if (w_lf || w_cr) n_mode = MODE_TAIL;
                    end
                    MODE_TAIL: begin
                        if (!(w_lf || w_cr)) disp = 1'b1;
                    end
                    MODE_ERROR: ;
                    default: disp = 1'b1;
                endcase
                if (disp) begin
                    n_mode = MODE_IDLE;
                    if (w_space) begin
                        n_mode = MODE_IDLE;
                    end else if (w_alpha || (c == C_UNDER)) begin
                        n_mode  = MODE_IDENT;
                        n_begin = r_pos;
                    end else if (w_digit) begin
                        n_mode  = MODE_NUMBER;
                        n_begin = r_pos;
                    end else if (c == C_QUOTE) begin
                        n_mode  = MODE_STRING;
                        n_begin = w_pos_p1;
                        n_esc   = 1'b0;
                        n_bs    = 1'b0;
                    end else if (c == C_SEMI) begin
                        n_mode = MODE_COMMENT;
                    end else if (c == C_PERCENT) begin
                        n_mode = MODE_ERROR;
                    end else if (w_single == K_NONE) begin
                        n_mode = MODE_ERROR;
                    end
                end
            end
        end
    end

    // tokens produced by the accepted byte
    always_comb begin
        logic disp;
        logic pre;
        logic eff_any, eff_prev;
        w_res[0] = mk_result(K_END, '0, '0, E_NONE);
        w_res[1] = mk_result(K_END, '0, '0, E_NONE);
        w_n      = 2'd0;
        disp     = 1'b0;
        pre      = 1'b0;
        eff_any  = 1'b0;
        eff_prev = 1'b0;
        if (w_accept) begin
            if (w_nul) begin
                if (r_mode == MODE_IDENT) begin
                    w_res[0] = mk_result(K_IDENT, w_begin16, w_span16, E_NONE);
                    w_n      = 2'd1;
                end else if (r_mode == MODE_NUMBER) begin
                    w_res[0] = mk_result(K_NUMBER, w_begin16, w_span16, E_NONE);
                    w_n      = 2'd1;
                end else if (r_mode == MODE_STRING) begin
                    w_res[0] = mk_result(K_ERROR, w_pos16, '0,
                                         r_bs ? E_ESC_QUOTE : E_UNCLOSED);
                    w_n      = 2'd1;
                end
                w_res[w_n[0]] = mk_result(K_END, w_pos16, '0, E_NONE);
                w_n           = w_n + 2'd1;
            end else begin
                unique case (r_mode)
                    MODE_IDENT: begin
                        if (!w_ident_c) begin
                            w_res[0] = mk_result((c == C_COLON) ? K_LABEL : K_IDENT,
                                                 w_begin16, w_span16, E_NONE);
                            w_n      = 2'd1;
                            pre      = 1'b1;
                            disp     = (c != C_COLON);
                        end
                    end
                    MODE_NUMBER: begin
                        if (!w_digit) begin
                            if (w_space || (w_single != K_NONE)) begin
                                w_res[0] = mk_result(K_NUMBER, w_begin16, w_span16, E_NONE);
                                pre      = 1'b1;
                                disp     = 1'b1;
                            end else begin
                                w_res[0] = mk_result(K_ERROR, w_pos16, '0, E_BAD_NUM);
                            end
                            w_n = 2'd1;
                        end
                    end
                    MODE_STRING: begin
                        if (!r_bs && (c == C_QUOTE)) begin
                            w_res[0] = r_esc ? mk_result(K_ERROR, w_pos16, '0, E_ESC_QUOTE)
                                             : mk_result(K_STRING, w_begin16, w_span16,
                                                         E_NONE);
                            w_n      = 2'd1;
                        end
                    end
                    MODE_COMMENT: ;
                    MODE_TAIL: disp = !(w_lf || w_cr);
                    MODE_ERROR: ;
                    default: disp = 1'b1;
                endcase
                eff_any  = r_any | pre;
                eff_prev = r_prev_break & ~pre;
                if (disp) begin
                    if (w_lf) begin
                        if (eff_any && !eff_prev) begin
                            w_res[w_n[0]] = mk_result(K_BREAK, w_pos16, 16'd1, E_NONE);
                            w_n           = w_n + 2'd1;
                        end
                    end else if (w_space || w_alpha || w_digit || (c == C_UNDER)
                                 || (c == C_QUOTE) || (c == C_SEMI)) begin
                        w_n = w_n;
                    end else if (c == C_PERCENT) begin
                        w_res[w_n[0]] = mk_result(K_ERROR, w_pos16, '0, E_DIRECTIVE);
                        w_n           = w_n + 2'd1;
                    end else if (w_single != K_NONE) begin
                        w_res[w_n[0]] = mk_result(w_single, w_pos16, 16'd1, E_NONE);
                        w_n           = w_n + 2'd1;
                    end else begin
                        w_res[w_n[0]] = mk_result(K_ERROR, w_pos16, '0, E_UNKNOWN);
                        w_n           = w_n + 2'd1;
                    end
                end
            end
            if (w_n == 2'd1) w_res[0].last = 1'b1;
            if (w_n == 2'd2) w_res[1].last = 1'b1;
        end
    end

    // line-break bookkeeping follows the tokens in order
    always_comb begin
        n_prev_break = r_prev_break;
        n_any        = r_any;
        if (w_accept) begin
            if (w_nul) begin
                n_prev_break = 1'b0;
                n_any        = 1'b0;
            end else begin
                for (int i = 0; i < 2; i++) begin
                    if (i < int'(w_n)) begin
                        if (w_res[i].kind == K_BREAK) begin
                            n_prev_break = 1'b1;
                        end else if (w_res[i].kind != K_ERROR && w_res[i].kind != K_END) begin
                            n_prev_break = 1'b0;
                            n_any        = 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign n_count = r_count + (PTR_W+1)'(w_n) - (PTR_W+1)'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_pos        <= '0;
            r_begin      <= '0;
            r_esc        <= 1'b0;
            r_bs         <= 1'b0;
            r_prev_break <= 1'b0;
            r_any        <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            r_mode       <= n_mode;
            r_pos        <= n_pos;
            r_begin      <= n_begin;
            r_esc        <= n_esc;
            r_bs         <= n_bs;
            r_prev_break <= n_prev_break;
            r_any        <= n_any;
            r_wr_ptr     <= r_wr_ptr + PTR_W'(w_n);
            r_rd_ptr     <= r_rd_ptr + PTR_W'(w_pop);
            r_count      <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_n != 2'd0) r_fifo[r_wr_ptr] <= w_res[0];
        if (w_n == 2'd2) r_fifo[r_wr_ptr + PTR_W'(1)] <= w_res[1];
    end

    assign s_axis_tready = (r_count <= (PTR_W+1)'(DEPTH - 2));
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_fifo[r_rd_ptr].err, r_fifo[r_rd_ptr].length,
                            r_fifo[r_rd_ptr].start};
    assign m_axis_tuser  = r_fifo[r_rd_ptr].kind;
    assign m_axis_tlast  = r_fifo[r_rd_ptr].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W+1)'(DEPTH))
        else $error("result queue overflow");

    a_nul_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_nul) |=> (r_pos == '0) && (r_mode == MODE_IDLE) && !r_any)
        else $error("end of text did not restart scan state");

    a_nul_gives_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_nul) |-> (w_n != 2'd0) && w_res[w_n[0] ^ 1'b1].last)
        else $error("end of text produced no closing token");

    a_error_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_nul && r_mode == MODE_ERROR) |-> (w_n == 2'd0))
        else $error("tokens produced after latched error");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == K_END) |-> m_axis_tlast)
        else $error("end token not marked last");

endmodule
